>>> hdl/klvp_pkg.sv
// Shared types and constants for the KLV local set parser.
// Depends on nothing; imported by every file but klvp_checker.
package klvp_pkg;

   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_HDR_HI   = 4'd1,
      PH_HDR_LO   = 4'd2,
      PH_SEEK     = 4'd3,
      PH_KEY      = 4'd4,
      PH_BER_LONG = 4'd5,
      PH_TAG0     = 4'd6,
      PH_TAG1     = 4'd7,
      PH_TAG2     = 4'd8,
      PH_TAG3     = 4'd9,
      PH_VALUE    = 4'd10,
      PH_DONE     = 4'd11
   } phase_type;

   localparam logic [7:0]  KEY_BYTE0     = 8'h06;
   localparam logic [7:0]  KEY_BYTE1     = 8'h0e;
   localparam logic [7:0]  KEY_BYTE2     = 8'h2b;
   localparam logic [7:0]  KEY_BYTE3     = 8'h34;
   localparam logic [7:0]  BER_LONG_FLAG = 8'h80;
   localparam logic [7:0]  BER_COUNT_MSK = 8'h7f;
   localparam logic [17:0] SET_MIN_BYTES = 18'd17;
   localparam logic [16:0] KEY_LAST_OFF  = 17'd16;
   localparam logic [17:0] ITEM_HDR_LEN  = 18'd4;

   // Parser state apart from the set length, whose width is a parameter.
   typedef struct packed {
      phase_type   phase;
      logic [16:0] byte_position;
      logic [15:0] size_limit;
      logic [16:0] next_set_start;
      logic [6:0]  ber_bytes_left;
      logic [16:0] set_end;
      logic [15:0] current_tag;
      logic [15:0] current_length;
      logic [15:0] value_count;
   } parse_state_type;

   // One result item.
   typedef struct packed {
      logic [15:0] tag;
      logic [7:0]  value_byte;
      logic [15:0] byte_index;
      logic [15:0] value_length;
      logic        last_of_value;
      logic        empty_value;
   } result_type;

   function automatic logic [7:0] key_prefix(input logic [1:0] idx);
      logic [7:0] k;
      case (idx)
         2'd0:    k = KEY_BYTE0;
         2'd1:    k = KEY_BYTE1;
         2'd2:    k = KEY_BYTE2;
         default: k = KEY_BYTE3;
      endcase
      return k;
   endfunction

endpackage

>>> hdl/klvp_step.sv
// Next-state and result logic for one packet byte of the KLV parser.
// Purely combinational; depends on klvp_pkg.
module klvp_step import klvp_pkg::*; #(
   parameter int LENGTH_BITS = 16
) (
   input  parse_state_type        cur_state,
   input  logic [LENGTH_BITS-1:0] cur_set_length,
   input  logic [7:0]             byte_value,
   input  logic                   first_byte,
   input  logic [15:0]            packet_size,
   output parse_state_type        nxt_state,
   output logic [LENGTH_BITS-1:0] nxt_set_length,
   output logic                   res_valid,
   output result_type             res
);

   localparam int SUMW = ((LENGTH_BITS > 17) ? LENGTH_BITS : 17) + 1;

   parse_state_type        st;
   logic [LENGTH_BITS-1:0] len;
   logic [16:0]            pos;
   logic [17:0]            body;
   logic [16:0]            off;
   logic [15:0]            tag_len;
   logic [LENGTH_BITS+7:0] shifted;
   logic [LENGTH_BITS-1:0] fin_len;
   logic [SUMW-1:0]        fin_sum;
   logic [6:0]             ber_dec;
   logic                   do_finish;
   logic                   do_begin;
   logic                   active;
   logic                   last;

   always_comb begin
      st = cur_state;
      len = cur_set_length;
      if (first_byte) begin
         st = '0;
         st.phase = PH_HDR_HI;
         st.size_limit = packet_size;
         len = '0;
      end
      nxt_state = st;
      nxt_set_length = len;
      res_valid = 1'b0;
      res = '0;
      do_finish = 1'b0;
      do_begin = 1'b0;
      fin_len = len;
      pos = st.byte_position;
      body = {1'b0, pos} + 18'd1;
      off = pos - st.next_set_start;
      tag_len = {st.current_length[15:8], byte_value};
      shifted = {len, byte_value};
      ber_dec = st.ber_bytes_left - 7'd1;
      last = ({1'b0, st.value_count} + 17'd1) >= {1'b0, st.current_length};
      active = !(st.phase == PH_IDLE || st.phase == PH_DONE ||
                 st.byte_position >= {1'b0, st.size_limit});

      if (active) begin
         unique case (st.phase)
            PH_HDR_HI: begin
               nxt_state.next_set_start = {1'b0, byte_value, 8'h00};
               nxt_state.phase = PH_HDR_LO;
            end
            PH_HDR_LO: begin
               nxt_state.next_set_start = {1'b0, st.next_set_start[15:8], byte_value};
               nxt_state.phase = ({st.next_set_start[15:8], byte_value} < 16'd2) ?
                                 PH_DONE : PH_SEEK;
            end
            PH_SEEK: begin
               if (pos == st.next_set_start) begin
                  if (({1'b0, st.next_set_start} + SET_MIN_BYTES > {2'b00, st.size_limit})
                      || byte_value != KEY_BYTE0) begin
                     nxt_state.phase = PH_DONE;
                  end else begin
                     nxt_state.phase = PH_KEY;
                  end
               end
            end
            PH_KEY: begin
               if (off < 17'd4) begin
                  if (byte_value != key_prefix(off[1:0])) begin
                     nxt_state.phase = PH_DONE;
                  end
               end else if (off == KEY_LAST_OFF) begin
                  if ((byte_value & BER_LONG_FLAG) != 8'h00) begin
                     nxt_state.ber_bytes_left = 7'(byte_value & BER_COUNT_MSK);
                     nxt_set_length = '0;
                     if (body + 18'(byte_value & BER_COUNT_MSK) > {2'b00, st.size_limit}) begin
                        nxt_state.phase = PH_DONE;
                     end else if ((byte_value & BER_COUNT_MSK) == 8'h00) begin
                        do_finish = 1'b1;
                        fin_len = '0;
                     end else begin
                        nxt_state.phase = PH_BER_LONG;
                     end
                  end else begin
                     do_finish = 1'b1;
                     fin_len = LENGTH_BITS'(byte_value);
                     nxt_set_length = fin_len;
                  end
               end
            end
            PH_BER_LONG: begin
               // The accumulator saturates once another byte would overflow it.
               if (shifted[LENGTH_BITS+7:LENGTH_BITS] != 8'h00) begin
                  fin_len = '1;
               end else begin
                  fin_len = shifted[LENGTH_BITS-1:0];
               end
               nxt_set_length = fin_len;
               nxt_state.ber_bytes_left = ber_dec;
               if (ber_dec == 7'd0) begin
                  do_finish = 1'b1;
               end
            end
            PH_TAG0: begin
               nxt_state.current_tag = {byte_value, 8'h00};
               nxt_state.phase = PH_TAG1;
            end
            PH_TAG1: begin
               nxt_state.current_tag = {st.current_tag[15:8], byte_value};
               nxt_state.phase = PH_TAG2;
            end
            PH_TAG2: begin
               nxt_state.current_length = {byte_value, 8'h00};
               nxt_state.phase = PH_TAG3;
            end
            PH_TAG3: begin
               nxt_state.current_length = tag_len;
               if (body + {2'b00, tag_len} > {1'b0, st.set_end}) begin
                  nxt_state.phase = PH_SEEK;
               end else if (tag_len == 16'd0) begin
                  res_valid = 1'b1;
                  res.tag = st.current_tag;
                  res.last_of_value = 1'b1;
                  res.empty_value = 1'b1;
                  do_begin = 1'b1;
               end else begin
                  nxt_state.value_count = '0;
                  nxt_state.phase = PH_VALUE;
               end
            end
            PH_VALUE: begin
               res_valid = 1'b1;
               res.tag = st.current_tag;
               res.value_byte = byte_value;
               res.byte_index = st.value_count;
               res.value_length = st.current_length;
               res.last_of_value = last;
               nxt_state.value_count = st.value_count + 16'd1;
               do_begin = last;
            end
            default: begin
               nxt_state.phase = PH_DONE;
            end
         endcase
         nxt_state.byte_position = pos + 17'd1;
      end

      fin_sum = SUMW'(body) + SUMW'(fin_len);
      if (do_finish) begin
         if (fin_sum > SUMW'(st.size_limit)) begin
            nxt_state.phase = PH_DONE;
         end else begin
            nxt_state.set_end = fin_sum[16:0];
            nxt_state.next_set_start = fin_sum[16:0];
            nxt_state.phase = (SUMW'(body + ITEM_HDR_LEN) > fin_sum) ? PH_SEEK : PH_TAG0;
         end
      end
      if (do_begin) begin
         nxt_state.phase = (body + ITEM_HDR_LEN > {1'b0, st.set_end}) ? PH_SEEK : PH_TAG0;
      end
   end

endmodule

>>> hdl/klvp_out.sv
// Result register of the KLV parser: holds one result until the sink takes it.
// Depends on klvp_pkg.
module klvp_out import klvp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type load_data,
   output logic       space,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   logic       valid_ff;
   logic       valid_in;
   result_type data_ff;

   // A new result may enter in the same cycle as the held one leaves.
   assign space = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (space) begin
         valid_in = load;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (space && load) begin
         data_ff <= load_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> hdl/klv_local_set_parser.sv
// KLV local set parser: one packet byte per request, at most one value byte out.
// A result is registered: it shows on rsp_ in the cycle after its request is taken.
// Throughput: one request per cycle; the single result register is the only
// buffer, and a request is taken whenever that register is empty or draining.
// Reset (synchronous, active high) returns the parser to idle and empties the
// result register. Depends on klvp_pkg, klvp_step and klvp_out.
module klv_local_set_parser import klvp_pkg::*; #(
   parameter int LENGTH_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // byte_value[7:0], packet_size[23:8]
   input  logic        req_tuser,   // first_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // tag[15:0], value_byte[23:16],
                                    // byte_index[39:24], value_length[55:40]
   output logic        rsp_tlast,   // last_of_value
   output logic        rsp_tuser    // empty_value
);

   parse_state_type        state_ff;
   parse_state_type        state_in;
   logic [LENGTH_BITS-1:0] set_length_ff;
   logic [LENGTH_BITS-1:0] set_length_in;
   logic                   res_valid;
   result_type             res;
   result_type             rsp_data;
   logic                   accept;

   assign accept = req_tvalid && req_tready;

   klvp_step #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_step (
      .cur_state      (state_ff),
      .cur_set_length (set_length_ff),
      .byte_value     (req_tdata[7:0]),
      .first_byte     (req_tuser),
      .packet_size    (req_tdata[23:8]),
      .nxt_state      (state_in),
      .nxt_set_length (set_length_in),
      .res_valid      (res_valid),
      .res            (res)
   );

   // An all-zero state is the idle phase with every counter cleared.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         set_length_ff <= '0;
      end else if (accept) begin
         state_ff <= state_in;
         set_length_ff <= set_length_in;
      end
   end

   klvp_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (accept && res_valid),
      .load_data (res),
      .space     (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_data)
   );

   assign rsp_tdata = {rsp_data.value_length, rsp_data.byte_index,
                       rsp_data.value_byte, rsp_data.tag};
   assign rsp_tlast = rsp_data.last_of_value;
   assign rsp_tuser = rsp_data.empty_value;

endmodule

>>> hdl/klvp_checker.sv
// Port-level checks for klv_local_set_parser, attached by the bind below.
// Depends only on the top level's ports.
module klvp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        rsp_tuser
);

   // A stalled result must hold.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // Reset empties the result register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // An empty value is a last item carrying zero byte, index and length.
   a_empty_form: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast && rsp_tdata[55:16] == 40'd0)
      else $error("malformed empty-value result");

   // The last byte of a value sits at index length - 1.
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast && !rsp_tuser |->
      {1'b0, rsp_tdata[39:24]} + 17'd1 == {1'b0, rsp_tdata[55:40]})
      else $error("last byte index does not match value length");

   // A byte that is not last lies strictly inside the value.
   a_mid_index: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |->
      {1'b0, rsp_tdata[39:24]} + 17'd1 < {1'b0, rsp_tdata[55:40]})
      else $error("value byte index out of range");

endmodule

bind klv_local_set_parser klvp_checker u_klvp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

>>> tb/klv_local_set_parser_test.sv
// Self-checking testbench for klv_local_set_parser: packet bytes in, tagged value bytes out.
// Depends on klvp_pkg and the parser RTL. Each result is compared with an in-bench
// model of the parser, or with the expected value given in a typed directed row.
module klv_local_set_parser_test import klvp_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [31:0] KEY_WORD = {KEY_BYTE0, KEY_BYTE1, KEY_BYTE2, KEY_BYTE3};
   localparam int unsigned BYTE_TARGET = 650;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // byte_value[7:0], packet_size[23:8]
   logic        req_tuser = 1'b0; // first_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;        // tag[15:0], value_byte[23:16],
                                  // byte_index[39:24], value_length[55:40]
   logic        rsp_tlast;        // last_of_value
   logic        rsp_tuser;        // empty_value

   klv_local_set_parser uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always #4 clock = ~clock;

   // One row of the directed stimulus; want is used only when typed is set.
   typedef struct {
      logic [7:0]  value;
      bit          first;
      logic [15:0] size;
      bit          typed;
      result_type  want;
   } stim_row_type;

   stim_row_type stim_rows [$];
   result_type   pending_values [$];
   logic [7:0]   pkt_bytes [$];
   logic [15:0]  pkt_size;

   bit          calm = 1'b0;
   int unsigned mismatches = 0;
   int unsigned values_seen = 0;
   int unsigned empties_seen = 0;
   int unsigned packets_sent = 0;
   int unsigned bytes_in_packets = 0;

   // Model of the parser state.
   phase_type   parse_ph;
   logic [16:0] parse_pos;
   logic [15:0] parse_limit;
   logic [16:0] set_start;
   logic [6:0]  ber_left;
   logic [16:0] set_len;
   logic [16:0] set_stop;
   logic [15:0] item_tag;
   logic [15:0] item_len;
   logic [15:0] item_count;

   task automatic note_mismatch(input string msg);
      if (mismatches < 40)
         $display("%0t ns mismatch: %s", $realtime, msg);
      mismatches++;
   endtask

   function automatic void clear_parser();
      parse_ph    = PH_IDLE;
      parse_pos   = '0;
      parse_limit = '0;
      set_start   = '0;
      ber_left    = '0;
      set_len     = '0;
      set_stop    = '0;
      item_tag    = '0;
      item_len    = '0;
      item_count  = '0;
   endfunction

   // Another tag needs a full 4-byte header inside the set; otherwise skip to the next set.
   function automatic void next_item(input int unsigned nxt);
      parse_ph = (nxt + 4 > set_stop) ? PH_SEEK : PH_TAG0;
   endfunction

   function automatic void close_length(input int unsigned body);
      if (body + set_len > parse_limit) begin
         parse_ph = PH_DONE;
      end else begin
         set_stop  = 17'(body + set_len);
         set_start = set_stop;
         next_item(body);
      end
   endfunction

   function automatic bit parse_byte(input logic [7:0] b, input bit first,
                                     input logic [15:0] size, output result_type r);
      int unsigned pos;
      int unsigned off;
      bit          hit;
      bit          last;
      r   = '0;
      hit = 1'b0;
      if (first) begin
         clear_parser();
         parse_limit = size;
         parse_ph    = PH_HDR_HI;
      end
      if (parse_ph == PH_IDLE || parse_ph == PH_DONE || parse_pos >= parse_limit)
         return 1'b0;
      pos = parse_pos;
      case (parse_ph)
         PH_HDR_HI: begin
            set_start = {1'b0, b, 8'h00};
            parse_ph  = PH_HDR_LO;
         end
         PH_HDR_LO: begin
            set_start = {set_start[16:8], b};
            parse_ph  = (set_start < 2) ? PH_DONE : PH_SEEK;
         end
         PH_SEEK: begin
            if (pos == set_start) begin
               if (set_start + SET_MIN_BYTES > parse_limit || b != KEY_BYTE0)
                  parse_ph = PH_DONE;
               else
                  parse_ph = PH_KEY;
            end
         end
         PH_KEY: begin
            off = pos - set_start;
            if (off < 4) begin
               if (b != KEY_WORD[31 - 8 * off -: 8])
                  parse_ph = PH_DONE;
            end else if (off == KEY_LAST_OFF) begin
               if ((b & BER_LONG_FLAG) != 0) begin
                  ber_left = b[6:0];
                  set_len  = '0;
                  if (pos + 1 + ber_left > parse_limit)
                     parse_ph = PH_DONE;
                  else if (ber_left == 0)
                     close_length(pos + 1);
                  else
                     parse_ph = PH_BER_LONG;
               end else begin
                  set_len = {9'd0, b};
                  close_length(pos + 1);
               end
            end
         end
         PH_BER_LONG: begin
            // The accumulator saturates once another byte would push it past 16 bits.
            if (set_len > 17'h000ff)
               set_len = 17'h0ffff;
            else
               set_len = {1'b0, set_len[7:0], b};
            ber_left = ber_left - 7'd1;
            if (ber_left == 0)
               close_length(pos + 1);
         end
         PH_TAG0: begin
            item_tag = {b, 8'h00};
            parse_ph = PH_TAG1;
         end
         PH_TAG1: begin
            item_tag = {item_tag[15:8], b};
            parse_ph = PH_TAG2;
         end
         PH_TAG2: begin
            item_len = {b, 8'h00};
            parse_ph = PH_TAG3;
         end
         PH_TAG3: begin
            item_len = {item_len[15:8], b};
            if (pos + 1 + item_len > set_stop) begin
               parse_ph = PH_SEEK;
            end else if (item_len == 0) begin
               r.tag           = item_tag;
               r.last_of_value = 1'b1;
               r.empty_value   = 1'b1;
               hit = 1'b1;
               next_item(pos + 1);
            end else begin
               item_count = '0;
               parse_ph   = PH_VALUE;
            end
         end
         PH_VALUE: begin
            last = (item_count + 1 >= item_len);
            r.tag           = item_tag;
            r.value_byte    = b;
            r.byte_index    = item_count;
            r.value_length  = item_len;
            r.last_of_value = last;
            hit = 1'b1;
            item_count = item_count + 16'd1;
            if (last)
               next_item(pos + 1);
         end
         default: begin
            parse_ph = PH_DONE;
         end
      endcase
      parse_pos = 17'(pos + 1);
      return hit;
   endfunction

   task automatic row(input logic [7:0] value, input bit first, input logic [15:0] size,
                      input bit typed, input result_type want);
      stim_row_type s;
      s.value = value;
      s.first = first;
      s.size  = size;
      s.typed = typed;
      s.want  = want;
      stim_rows.insert(stim_rows.size(), s);
   endtask

   // Drives one request and records what it should produce once it is taken.
   task automatic send_byte(input logic [7:0] value, input bit first, input logic [15:0] size,
                            input bit typed, input result_type want);
      result_type got;
      bit         emits;
      if (!calm && $urandom_range(99) < 13) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while (!calm && $urandom_range(99) < 13);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {size, value};
      req_tuser  <= first;
      do @(posedge clock); while (req_tready !== 1'b1);
      emits = parse_byte(value, first, size, got);
      if (typed)
         pending_values.insert(pending_values.size(), want);
      else if (emits)
         pending_values.insert(pending_values.size(), got);
   endtask

   task automatic await_values();
      int unsigned waited;
      waited = 0;
      req_tvalid <= 1'b0;
      while (pending_values.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      if (pending_values.size() != 0) begin
         note_mismatch($sformatf("%0d expected values never arrived", pending_values.size()));
         pending_values.delete();
      end
   endtask

   // Builds one packet: mostly well-formed local sets with random content, some broken.
   task automatic build_packet();
      logic [7:0]  body [$];
      int unsigned kind;
      int unsigned hdr;
      int unsigned vlen;
      int unsigned claim;
      int unsigned blen;
      int unsigned form;
      logic [15:0] tag;
      pkt_bytes.delete();
      kind = $urandom_range(99);
      if (kind < 8) begin
         repeat ($urandom_range(40, 1)) pkt_bytes.insert(pkt_bytes.size(), 8'($urandom));
         pkt_size = (kind < 4) ? 16'(pkt_bytes.size()) : 16'($urandom);
         return;
      end
      if (kind < 11)
         hdr = $urandom_range(1);
      else if (kind < 14)
         hdr = $urandom_range(65535);
      else
         hdr = $urandom_range(6, 2);
      pkt_bytes.insert(pkt_bytes.size(), 8'(hdr >> 8));
      pkt_bytes.insert(pkt_bytes.size(), 8'(hdr));
      if (kind >= 14)
         for (int i = 2; i < hdr; i++) pkt_bytes.insert(pkt_bytes.size(), 8'($urandom));
      repeat ($urandom_range(3, 1)) begin
         body.delete();
         repeat ($urandom_range(4)) begin
            tag   = 16'($urandom);
            vlen  = ($urandom_range(9) == 0) ? 0 : $urandom_range(5, 1);
            // Now and then a value claims more bytes than it carries.
            claim = ($urandom_range(11) == 0) ? vlen + $urandom_range(300, 1) : vlen;
            body.insert(body.size(), tag[15:8]);
            body.insert(body.size(), tag[7:0]);
            body.insert(body.size(), 8'(claim >> 8));
            body.insert(body.size(), 8'(claim));
            repeat (vlen) body.insert(body.size(), 8'($urandom));
         end
         if ($urandom_range(5) == 0)
            repeat ($urandom_range(3, 1)) body.insert(body.size(), 8'($urandom));
         for (int i = 0; i < 4; i++)
            pkt_bytes.insert(pkt_bytes.size(), KEY_WORD[31 - 8 * i -: 8]);
         if ($urandom_range(19) == 0)
            pkt_bytes[pkt_bytes.size() - 1 - $urandom_range(3)] ^= 8'($urandom_range(255, 1));
         repeat (12) pkt_bytes.insert(pkt_bytes.size(), 8'($urandom));
         blen = body.size();
         form = $urandom_range(19);
         if (form < 11) begin
            pkt_bytes.insert(pkt_bytes.size(), 8'(blen));
         end else if (form < 15) begin
            pkt_bytes.insert(pkt_bytes.size(), BER_LONG_FLAG | 8'd1);
            pkt_bytes.insert(pkt_bytes.size(), 8'(blen));
         end else if (form < 17) begin
            pkt_bytes.insert(pkt_bytes.size(), BER_LONG_FLAG | 8'd2);
            pkt_bytes.insert(pkt_bytes.size(), 8'h00);
            pkt_bytes.insert(pkt_bytes.size(), 8'(blen));
         end else if (form == 17) begin
            pkt_bytes.insert(pkt_bytes.size(), BER_LONG_FLAG);
            body.delete();
         end else if (form == 18) begin
            // Three length bytes starting with 01 overflow 16 bits and saturate.
            pkt_bytes.insert(pkt_bytes.size(), BER_LONG_FLAG | 8'd3);
            pkt_bytes.insert(pkt_bytes.size(), 8'h01);
            pkt_bytes.insert(pkt_bytes.size(), 8'($urandom));
            pkt_bytes.insert(pkt_bytes.size(), 8'($urandom));
         end else if ($urandom_range(1) == 0) begin
            pkt_bytes.insert(pkt_bytes.size(), 8'($urandom_range(127, blen + 1)));
         end else begin
            pkt_bytes.insert(pkt_bytes.size(), BER_LONG_FLAG | BER_COUNT_MSK);
         end
         foreach (body[i]) pkt_bytes.insert(pkt_bytes.size(), body[i]);
      end
      kind = $urandom_range(19);
      if (kind == 0) begin
         // A trailing stub that looks like a key but may be too short for a set.
         pkt_bytes.insert(pkt_bytes.size(), KEY_BYTE0);
         repeat ($urandom_range(19)) pkt_bytes.insert(pkt_bytes.size(), 8'($urandom));
         pkt_size = 16'(pkt_bytes.size());
      end else if (kind == 1) begin
         pkt_size = 16'($urandom_range(pkt_bytes.size() - 1, 1));
      end else if (kind == 2) begin
         pkt_size = 16'($urandom_range(65535, pkt_bytes.size()));
      end else begin
         pkt_size = 16'(pkt_bytes.size());
      end
   endtask

   always @(posedge clock) begin : rsp_side
      result_type seen;
      result_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         seen.tag           = rsp_tdata[15:0];
         seen.value_byte    = rsp_tdata[23:16];
         seen.byte_index    = rsp_tdata[39:24];
         seen.value_length  = rsp_tdata[55:40];
         seen.last_of_value = rsp_tlast;
         seen.empty_value   = rsp_tuser;
         if (pending_values.size() == 0) begin
            note_mismatch($sformatf("unexpected value for tag %h", seen.tag));
         end else begin
            want = pending_values.pop_front();
            if (seen.tag !== want.tag)
               note_mismatch($sformatf("tag %h, expected %h", seen.tag, want.tag));
            if (seen.value_byte !== want.value_byte)
               note_mismatch($sformatf("tag %h value byte %h, expected %h",
                                       want.tag, seen.value_byte, want.value_byte));
            if (seen.byte_index !== want.byte_index)
               note_mismatch($sformatf("tag %h byte index %0d, expected %0d",
                                       want.tag, seen.byte_index, want.byte_index));
            if (seen.value_length !== want.value_length)
               note_mismatch($sformatf("tag %h value length %0d, expected %0d",
                                       want.tag, seen.value_length, want.value_length));
            if (seen.last_of_value !== want.last_of_value)
               note_mismatch($sformatf("tag %h last flag %b, expected %b",
                                       want.tag, seen.last_of_value, want.last_of_value));
            if (seen.empty_value !== want.empty_value)
               note_mismatch($sformatf("tag %h empty flag %b, expected %b",
                                       want.tag, seen.empty_value, want.empty_value));
         end
         values_seen++;
         if (seen.empty_value === 1'b1)
            empties_seen++;
      end
      rsp_tready <= calm || ($urandom_range(99) >= 13);
   end

   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      bit paused;
      clear_parser();
      paused = 1'b0;

      // A byte before any packet start, an empty packet, then one complete set with an
      // empty value and a one-byte value at the extremes of tag and byte.
      row(8'ha5, 1'b0, 16'h0000, 1'b0, '0);
      row(8'h00, 1'b1, 16'h0000, 1'b0, '0);
      row(8'h00, 1'b1, 16'hffff, 1'b0, '0);
      row(8'h02, 1'b0, 16'h0000, 1'b0, '0);
      for (int i = 0; i < 4; i++) row(KEY_WORD[31 - 8 * i -: 8], 1'b0, 16'h0000, 1'b0, '0);
      for (int i = 0; i < 12; i++) row(i[0] ? 8'hff : 8'h00, 1'b0, 16'h0000, 1'b0, '0);
      row(8'h09, 1'b0, 16'h0000, 1'b0, '0);
      row(8'h00, 1'b0, 16'h0000, 1'b0, '0);
      row(8'h00, 1'b0, 16'h0000, 1'b0, '0);
      row(8'h00, 1'b0, 16'h0000, 1'b0, '0);
      row(8'h00, 1'b0, 16'h0000, 1'b1,
          '{tag: 16'h0000, value_byte: 8'h00, byte_index: 16'd0, value_length: 16'd0,
            last_of_value: 1'b1, empty_value: 1'b1});
      row(8'hff, 1'b0, 16'h0000, 1'b0, '0);
      row(8'hff, 1'b0, 16'h0000, 1'b0, '0);
      row(8'h00, 1'b0, 16'h0000, 1'b0, '0);
      row(8'h01, 1'b0, 16'h0000, 1'b0, '0);
      row(8'hff, 1'b0, 16'h0000, 1'b1,
          '{tag: 16'hffff, value_byte: 8'hff, byte_index: 16'd0, value_length: 16'd1,
            last_of_value: 1'b1, empty_value: 1'b0});

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_rows[i])
         send_byte(stim_rows[i].value, stim_rows[i].first, stim_rows[i].size,
                   stim_rows[i].typed, stim_rows[i].want);
      await_values();

      while (bytes_in_packets < BYTE_TARGET) begin
         calm = (bytes_in_packets >= 250 && bytes_in_packets < 350);
         if (!paused && bytes_in_packets >= 420) begin
            // Hold the sender off until the parser has delivered everything.
            await_values();
            paused = 1'b1;
         end
         build_packet();
         packets_sent++;
         foreach (pkt_bytes[i]) begin
            send_byte(pkt_bytes[i], i == 0, (i == 0) ? pkt_size : 16'($urandom), 1'b0, '0);
            if (i < pkt_size)
               bytes_in_packets++;
         end
      end
      calm = 1'b0;

      await_values();
      repeat (4) @(posedge clock);

      $display("Directed set plus %0d random packets (%0d bytes inside packet bounds).",
               packets_sent, bytes_in_packets);
      $display("Checked %0d value requests, %0d of them empty values; %0d mismatches.",
               values_seen, empties_seen, mismatches);
      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

>>> sim.f
hdl/klvp_pkg.sv
hdl/klvp_step.sv
hdl/klvp_out.sv
hdl/klv_local_set_parser.sv
hdl/klvp_checker.sv
tb/klv_local_set_parser_test.sv
